/* rtl/core/swmm_pkg.sv */
package swmm_pkg;

  // configuration register map
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int LEN_REG_W     = 7;
  localparam int REG_WINDOW_LEN = 0;

  // top level to one queue
  typedef struct packed {
    logic active;   // an item is held and being worked on
    logic insert;   // the held item is appended in this cycle
    logic restart;  // the held item starts a new sequence
  } swmm_ctrl_t;

  // one queue to top level
  typedef struct packed {
    logic need_purge;  // more than one front entry has aged out
  } swmm_status_t;

  // queue to each cell
  typedef struct packed {
    logic insert;   // drop dominated entries and append the sample
    logic purge;    // move every entry one cell toward the front only
    logic shift;    // source of each cell is its back neighbor
    logic restart;  // ignore all stored entries
  } swmm_cell_ctrl_t;

endpackage

/* rtl/core/swmm_in_if.sv */
interface swmm_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

/* rtl/core/swmm_out_if.sv */
interface swmm_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_min;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic                           full_res;

  modport source (output valid, output window_min, output window_max, output full_res,
                  input ready);
  modport sink   (input valid, input window_min, input window_max, input full_res,
                  output ready);
endinterface

/* rtl/core/swmm_cell.sv */
module swmm_cell import swmm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_W        = 7,
  parameter bit IS_MAX       = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swmm_cell_ctrl_t                ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_value,
  input  logic [AGE_W-1:0]               nxt_age,
  input  logic                           nxt_valid,
  input  logic                           nxt_keep,
  input  logic                           prev_keep,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic [AGE_W-1:0]               age,
  output logic                           valid,
  output logic                           keep
);

  logic                           dominated;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic [AGE_W-1:0]               src_age;
  logic                           src_valid;
  logic                           src_keep;
  logic signed [SAMPLE_WIDTH-1:0] value_next;
  logic [AGE_W-1:0]               age_next;
  logic                           valid_next;

  // an equal new sample replaces the stored one in both queues
  assign dominated = IS_MAX ? (value <= sample) : (value >= sample);
  assign keep      = valid & ~dominated & ~ctrl.restart;

  assign src_value = ctrl.shift ? nxt_value : value;
  assign src_age   = ctrl.shift ? nxt_age   : age;
  assign src_valid = ctrl.shift ? nxt_valid : valid;
  assign src_keep  = ctrl.shift ? nxt_keep  : keep;

  always_comb begin
    value_next = value;
    age_next   = age;
    valid_next = valid;
    if (ctrl.insert) begin
      if (src_keep) begin
        value_next = src_value;
        age_next   = src_age + AGE_W'(1);
        valid_next = 1'b1;
      end else if (prev_keep) begin
        // first free cell behind the survivors takes the sample
        value_next = sample;
        age_next   = '0;
        valid_next = 1'b1;
      end else begin
        valid_next = 1'b0;
      end
    end else if (ctrl.purge) begin
      value_next = src_value;
      age_next   = src_age;
      valid_next = src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
    age   <= age_next;
  end

endmodule

/* rtl/core/swmm_queue.sv */
module swmm_queue import swmm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int DEPTH        = 64,
  parameter int AGE_W        = 7,
  parameter bit IS_MAX       = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swmm_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [AGE_W-1:0]               len_m1,
  output swmm_status_t                   status,
  output logic signed [SAMPLE_WIDTH-1:0] front_next
);

  // one spare slot past the back acts as an always empty neighbor
  logic signed [SAMPLE_WIDTH-1:0] cval   [DEPTH+1];
  logic [AGE_W-1:0]               cage   [DEPTH+1];
  logic                           cvalid [DEPTH+1];
  logic                           ckeep  [DEPTH+1];
  logic                           expired0;
  logic                           expired1;
  logic                           purge_only;
  swmm_cell_ctrl_t                cell_ctrl;

  assign cval[DEPTH]   = '0;
  assign cage[DEPTH]   = '0;
  assign cvalid[DEPTH] = 1'b0;
  assign ckeep[DEPTH]  = 1'b0;

  // positions grow toward the back, so aged out entries form a prefix
  assign expired0 = cvalid[0] & (cage[0] >= len_m1) & ~ctrl.restart;
  assign expired1 = cvalid[1] & (cage[1] >= len_m1) & ~ctrl.restart;

  assign status.need_purge = expired0 & expired1;
  assign purge_only        = ctrl.active & ~ctrl.insert & status.need_purge;

  assign cell_ctrl.insert  = ctrl.insert;
  assign cell_ctrl.purge   = purge_only;
  assign cell_ctrl.shift   = ctrl.insert ? expired0 : purge_only;
  assign cell_ctrl.restart = ctrl.restart;

  // front entry after this insert
  always_comb begin
    if (expired0) begin
      front_next = ckeep[1] ? cval[1] : sample;
    end else begin
      front_next = ckeep[0] ? cval[0] : sample;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_keep;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_keep = cell_ctrl.shift ? ckeep[i] : ckeep[i-1];
    end

    swmm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W),
      .IS_MAX       (IS_MAX)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .sample    (sample),
      .nxt_value (cval[i+1]),
      .nxt_age   (cage[i+1]),
      .nxt_valid (cvalid[i+1]),
      .nxt_keep  (ckeep[i+1]),
      .prev_keep (prev_keep),
      .value     (cval[i]),
      .age       (cage[i]),
      .valid     (cvalid[i]),
      .keep      (ckeep[i])
    );
  end

endmodule

/* rtl/core/sliding_window_min_max.sv */
// Sliding window minimum and maximum of a signed sample stream. Each item
// carries one sample and a restart flag and yields one result item holding the
// minimum and maximum of the last window_len samples since the latest restart,
// plus full_res, which rises once window_len samples have been seen. Before
// that the result covers all samples since the restart. window_len (register 0,
// byte address 0) is used as 1 when written as 0 and as WINDOW_MAX above that,
// and is to be written only while the block is idle, which the block does not
// enforce. Internally two rows of WINDOW_MAX cells hold monotonic candidate
// queues, front in the first cell. Every cell compares its entry with the new
// sample at once, so dominated entries leave together and the first free cell
// takes the sample. The sustained rate is one item per cycle while the result
// register is free or read and no queue needs a purge step. Each taken item is
// held in a register, and its result is registered when the item is appended.
// After window_len is made shorter, the next item waits while the cell rows
// move to the front one cell per cycle until at most one entry is aged out.

module sliding_window_min_max import swmm_pkg::*; #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  swmm_in_if.sink            in_ch,
  swmm_out_if.source         out_ch
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

  // configuration
  logic [LEN_REG_W-1:0] window_len;
  logic [CMP_W-1:0]     len_wide;
  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     len_m1;
  logic                 cfg_write;

  // held item and sequencing
  logic                           busy;
  logic signed [SAMPLE_WIDTH-1:0] hold_sample;
  logic                           hold_restart;
  logic                           accept;
  logic                           go;
  logic [LEN_W-1:0]               seen_count;
  logic [LEN_W-1:0]               seen_count_next;

  // queues
  swmm_ctrl_t                     qctrl;
  swmm_status_t                   min_status;
  swmm_status_t                   max_status;
  logic signed [SAMPLE_WIDTH-1:0] min_front;
  logic signed [SAMPLE_WIDTH-1:0] max_front;

  // result register
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_min;
  logic signed [SAMPLE_WIDTH-1:0] out_max;
  logic                           out_full;

  // apb register port, no wait states; word index in paddr above the byte bits
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready
                     & (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_WINDOW_LEN));
  assign prdata    = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_WINDOW_LEN)) ?
                     DATA_W'(window_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_REG_W'(1);
    end else if (cfg_write) begin
      window_len <= pwdata[LEN_REG_W-1:0];
    end
  end

  // clamp window length into 1..WINDOW_MAX
  assign len_wide = CMP_W'(window_len);
  always_comb begin
    if (len_wide == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_wide > CMP_W'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = len_wide[LEN_W-1:0];
    end
  end
  assign len_m1 = len_eff - LEN_W'(1);

  // an item is appended once no queue needs a purge step and the result
  // register is free; a new item can be taken in that same cycle
  assign go           = busy & ~min_status.need_purge & ~max_status.need_purge
                        & (~out_valid | out_ch.ready);
  assign in_ch.ready  = ~rst & (~busy | go);
  assign accept       = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (go) begin
      busy <= 1'b0;
    end
    if (accept) begin
      hold_sample  <= in_ch.sample;
      hold_restart <= in_ch.restart;
    end
  end

  // samples since restart, saturating
  always_comb begin
    if (hold_restart) begin
      seen_count_next = LEN_W'(1);
    end else if (seen_count == LEN_W'(WINDOW_MAX)) begin
      seen_count_next = seen_count;
    end else begin
      seen_count_next = seen_count + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (go) begin
      seen_count <= seen_count_next;
    end
  end

  assign qctrl.active  = busy;
  assign qctrl.insert  = go;
  assign qctrl.restart = hold_restart;

  swmm_queue #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DEPTH        (WINDOW_MAX),
    .AGE_W        (LEN_W),
    .IS_MAX       (1'b0)
  ) u_min_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (qctrl),
    .sample     (hold_sample),
    .len_m1     (len_m1),
    .status     (min_status),
    .front_next (min_front)
  );

  swmm_queue #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DEPTH        (WINDOW_MAX),
    .AGE_W        (LEN_W),
    .IS_MAX       (1'b1)
  ) u_max_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (qctrl),
    .sample     (hold_sample),
    .len_m1     (len_m1),
    .status     (max_status),
    .front_next (max_front)
  );

  // result register parts the queues from the output channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (go) begin
      out_min  <= min_front;
      out_max  <= max_front;
      out_full <= (seen_count_next >= len_eff);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.window_min = out_min;
  assign out_ch.window_max = out_max;
  assign out_ch.full_res   = out_full;

  // both queues cover the same samples, so the fronts stay ordered
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_min <= out_max))
    else $error("window minimum above window maximum");

  // an appended item always leaves a result behind
  a_go_gives_result: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid)
    else $error("append without result");

  // a result waiting on the channel is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !go)
    else $error("pending result overwritten");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= LEN_W'(WINDOW_MAX))
    else $error("seen count above window capacity");

endmodule

/* verif/tb_sliding_window_min_max.sv */
module tb_sliding_window_min_max import swmm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX     = 64;
  localparam int SAMPLE_W    = 32;
  localparam int IDLE_LIMIT  = 3000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int EXP_DEPTH   = 64;    // expected results in flight, far above need

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

  // one candidate of a monotonic deque: value and its stream position
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [6:0]                 pos;
  } cand_t;

  // expected contents of one result item
  typedef struct {
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       full;
  } minmax_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  swmm_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  swmm_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

  sliding_window_min_max #(
    .WINDOW_MAX  (WIN_MAX),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: index 0 holds min candidates, index 1 max candidates,
  // oldest candidate at entry 0
  cand_t      cand_buf [2][WIN_MAX];
  int         cand_cnt [2];
  logic [6:0] win_len_reg;
  logic [6:0] cur_pos;
  logic [6:0] seen_cnt;

  // expected results, circular buffer
  minmax_t exp_buf [EXP_DEPTH];
  int      exp_head;
  int      exp_tail;
  int      exp_count;

  int  items_sent;
  int  results_checked;
  int  mismatches;
  int  restarts_sent;
  int  hold_off_req;
  bit  steady;          // no random idling on either side while set
  int  idle_cycles;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // remove the oldest candidate of one deque
  function automatic void drop_oldest(input int k);
    for (int j = 0; j + 1 < cand_cnt[k]; j++) cand_buf[k][j] = cand_buf[k][j+1];
    if (cand_cnt[k] > 0) cand_cnt[k]--;
  endfunction

  // window min/max predictor for one sample
  function automatic minmax_t predict_minmax(input logic signed [SAMPLE_W-1:0] s,
                                             input logic restart);
    minmax_t     r;
    int unsigned len;
    cand_t       c;
    bit          dominated;
    logic [6:0]  age;
    len = win_len_reg;
    if (len < 1) len = 1;
    if (len > WIN_MAX) len = WIN_MAX;
    if (restart) begin
      cand_cnt[0] = 0;
      cand_cnt[1] = 0;
      cur_pos  = '0;
      seen_cnt = '0;
    end
    for (int k = 0; k < 2; k++) begin
      // age out the front, then drop dominated entries at the back
      while (cand_cnt[k] > 0) begin
        age = cur_pos - cand_buf[k][0].pos;
        if (age < len) break;
        drop_oldest(k);
      end
      while (cand_cnt[k] > 0) begin
        c = cand_buf[k][cand_cnt[k]-1];
        dominated = (k == 1) ? (c.value <= s) : (c.value >= s);
        if (!dominated) break;
        cand_cnt[k]--;
      end
      if (cand_cnt[k] >= WIN_MAX) drop_oldest(k);
      c.value = s;
      c.pos   = cur_pos;
      cand_buf[k][cand_cnt[k]] = c;
      cand_cnt[k]++;
    end
    if (seen_cnt < WIN_MAX) seen_cnt++;
    cur_pos++;
    r.lo   = cand_buf[0][0].value;
    r.hi   = cand_buf[1][0].value;
    r.full = (seen_cnt >= len);
    return r;
  endfunction

  // offer one sample item, hold it until taken, then log its expected result
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    while (!steady && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_buf[exp_tail] = predict_minmax(s, restart);
    exp_tail = (exp_tail + 1) % EXP_DEPTH;
    exp_count++;
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  // stop offering and wait until every expected result has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (exp_count > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, register taken when pready is high
  task automatic write_window_len(input logic [6:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(REG_WINDOW_LEN * 4);
    pwdata  <= DATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    win_len_reg = len;
  endtask

  // reset value of the window is one: each result is the sample itself
  task automatic test_reset_length();
    send_item(S_MIN, 1'b1);
    send_item(S_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(-32'sd1, 1'b0);
    wait_drained();
  endtask

  // a window length of zero behaves as one
  task automatic test_length_zero();
    write_window_len(7'd0);
    send_item(32'sd7, 1'b0);
    send_item(-32'sd7, 1'b0);
    wait_drained();
  endtask

  // partial window after restart, repeated equal samples replacing old entries
  task automatic test_equal_and_partial();
    write_window_len(7'd3);
    send_item(32'sd10, 1'b1);
    send_item(32'sd10, 1'b0);
    send_item(32'sd10, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd10, 1'b0);
    send_item(32'sd10, 1'b0);
    wait_drained();
  endtask

  // shrinking the window mid stream ages out many front entries at once,
  // then growing it again without a restart
  task automatic test_shortened_window();
    write_window_len(7'd8);
    for (int i = 1; i <= 8; i++) send_item(32'(i), (i == 1));
    wait_drained();
    write_window_len(7'd2);
    send_item(32'sd100, 1'b0);
    wait_drained();
    write_window_len(7'd64);
    send_item(-32'sd5, 1'b0);
    wait_drained();
  endtask

  // one random phase at a given window setting; runs of random, narrow,
  // ramping and extreme samples, with occasional restarts
  task automatic test_random_phase(input logic [6:0] len, input int n_items,
                                   input bit fresh);
    int                         run_left;
    int                         mode;
    int                         step;
    logic signed [SAMPLE_W-1:0] ramp;
    logic signed [SAMPLE_W-1:0] s;
    logic                       restart;
    run_left = 0;
    mode     = 0;
    step     = 1;
    ramp     = '0;
    wait_drained();
    write_window_len(len);
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        mode = $urandom_range(4);
        step = $urandom_range(1, 1000);
        ramp = $signed($urandom);
        // long ramps fill the deques up to the full window
        if ((mode == 2 || mode == 3) && $urandom_range(3) == 0)
          run_left = $urandom_range(20, 70);
        else
          run_left = $urandom_range(1, 12);
      end
      run_left--;
      case (mode)
        0: s = $signed($urandom);
        1: s = $signed($urandom_range(6)) - 32'sd3;
        2: begin
          ramp = ramp + step;
          s    = ramp;
        end
        3: begin
          ramp = ramp - step;
          s    = ramp;
        end
        default: begin
          case ($urandom_range(3))
            0: s = S_MIN;
            1: s = S_MAX;
            2: s = '0;
            default: s = -32'sd1;
          endcase
        end
      endcase
      restart = (i == 0 && fresh) || ($urandom_range(49) == 0);
      send_item(s, restart);
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its
  // input while items keep being offered; then the sender pauses until
  // everything is out
  task automatic test_backpressure();
    wait_drained();
    write_window_len(7'd6);
    hold_off_req = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) send_item($signed($urandom), (i == 0));
    wait_drained();
    for (int i = 0; i < 10; i++) send_item($signed($urandom_range(20)) - 32'sd10, 1'b0);
    wait_drained();
  endtask

  // result checker and receiver ready generation, one process
  initial begin : result_side
    int hold_left;
    minmax_t exp_r;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (exp_count == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: min %0d max %0d full %0b",
                     out_ch.window_min, out_ch.window_max, out_ch.full_res);
        end else begin
          exp_r = exp_buf[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          if (out_ch.window_min !== exp_r.lo || out_ch.window_max !== exp_r.hi ||
              out_ch.full_res !== exp_r.full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: min exp %0d got %0d, max exp %0d got %0d, %s",
                       results_checked, exp_r.lo, out_ch.window_min, exp_r.hi,
                       out_ch.window_max,
                       $sformatf("full exp %0b got %0b", exp_r.full, out_ch.full_res));
          end
        end
      end
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  // watchdog: too long with no item moving on either channel
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, exp_count);
        $display("tb_sliding_window_min_max failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    win_len_reg   = 7'd1;
    cur_pos       = '0;
    seen_cnt      = '0;
    cand_cnt[0]   = 0;
    cand_cnt[1]   = 0;
    exp_head      = 0;
    exp_tail      = 0;
    exp_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    mismatches      = 0;
    restarts_sent   = 0;
    hold_off_req    = 0;
    steady          = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    test_reset_length();
    test_length_zero();
    test_equal_and_partial();
    test_shortened_window();

    // random part: several window settings including both extremes and
    // out-of-range writes; phases without restart change the length mid stream
    test_random_phase(7'd4,   50, 1'b1);
    test_random_phase(7'd1,   30, 1'b0);
    test_random_phase(7'd64,  80, 1'b1);
    test_random_phase(7'd2,   40, 1'b0);
    test_random_phase(7'd127, 50, 1'b0);
    test_random_phase(7'd0,   30, 1'b0);
    test_random_phase(7'd9,   50, 1'b1);
    steady = 1'b1;
    test_random_phase(7'd100, 50, 1'b1);
    steady = 1'b0;
    test_random_phase(7'd3,   40, 1'b0);
    test_random_phase(7'($urandom_range(1, 16)), 40, 1'b0);
    test_backpressure();
    test_random_phase(7'd20,  30, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    mismatches += exp_count;

    $display("run covered %0d sample items (%0d with restart) and %0d result items,",
             items_sent, restarts_sent, results_checked);
    $display("window lengths 0 to 127, shrink and grow mid stream, long output stall");
    if (mismatches == 0) begin
      $display("tb_sliding_window_min_max passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_sliding_window_min_max failed");
    end
    $finish;
  end

endmodule
